[hw/rtl/transposition_table_probe_store_defines.svh]
// Assertion helpers used by the top-level RTL file.
`ifndef TRANSPOSITION_TABLE_PROBE_STORE_DEFINES_SVH
`define TRANSPOSITION_TABLE_PROBE_STORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TTPS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("check failed: lbl");

// Next-cycle implication, checked out of reset.
`define TTPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("check failed: lbl");

`endif

[hw/rtl/ttps_pkg.sv]
`timescale 1ns / 1ps

package ttps_pkg;

    // Table geometry
    localparam int INDEX_BITS  = 11;
    localparam int TABLE_DEPTH = 1 << INDEX_BITS;
    localparam int KEY_BITS    = 32;
    localparam int TAG_BITS    = KEY_BITS - INDEX_BITS;
    localparam int DEPTH_BITS  = 7;
    localparam int THR_BITS    = 15;

    // Operation codes
    localparam logic OP_PROBE = 1'b0;
    localparam logic OP_STORE = 1'b1;

    // Bound kinds on the request
    localparam logic [1:0] BOUND_EXACT = 2'd0;
    localparam logic [1:0] BOUND_UPPER = 2'd1;
    localparam logic [1:0] BOUND_LOWER = 2'd2;

    // Entry kinds held in the table
    localparam logic [1:0] KIND_EMPTY = 2'd0;
    localparam logic [1:0] KIND_EXACT = 2'd1;
    localparam logic [1:0] KIND_UPPER = 2'd2;
    localparam logic [1:0] KIND_LOWER = 2'd3;

    localparam logic [THR_BITS-1:0] MATE_THRESHOLD_RESET = 15'd31000;

    typedef struct packed {
        logic                    operation;
        logic [KEY_BITS-1:0]     position_key;
        logic [DEPTH_BITS-1:0]   search_depth;
        logic [DEPTH_BITS-1:0]   ply_distance;
        logic signed [15:0]      store_score;
        logic [1:0]              bound_kind;
        logic [15:0]             packed_move;
        logic signed [15:0]      window_low;
        logic signed [15:0]      window_high;
    } t_in;

    typedef struct packed {
        logic                    hit;
        logic [15:0]             move_hint;
        logic                    cutoff;
        logic signed [15:0]      cutoff_score;
    } t_out;

    // One table entry; the index bits of the key are implied by the address
    typedef struct packed {
        logic [TAG_BITS-1:0]     tag;
        logic [15:0]             score;
        logic [15:0]             move;
        logic [DEPTH_BITS-1:0]   depth;
        logic [1:0]              kind;
    } t_entry;

    localparam int ENTRY_BITS = $bits(t_entry);

    // Table write request
    typedef struct packed {
        logic                    en;
        logic [INDEX_BITS-1:0]   idx;
        t_entry                  entry;
    } t_wr;

endpackage

[hw/rtl/ttps_ram.sv]
`timescale 1ns / 1ps

module ttps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; data holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/ttps_eval.sv]
`timescale 1ns / 1ps

module ttps_eval (
    input  ttps_pkg::t_in                         i_req,
    input  ttps_pkg::t_entry                      i_entry,
    input  logic [ttps_pkg::THR_BITS-1:0]         i_threshold,
    output ttps_pkg::t_out                        o_result,
    output ttps_pkg::t_wr                         o_wr
);

    logic                              is_store;
    logic [ttps_pkg::TAG_BITS-1:0]     req_tag;
    logic                              key_match;
    logic                              keep_old;
    logic signed [17:0]                thr;
    logic signed [17:0]                ply;
    logic signed [17:0]                in_score;
    logic signed [17:0]                in_shifted;
    logic signed [17:0]                st_score;
    logic signed [17:0]                out_shifted;
    logic signed [17:0]                alpha;
    logic signed [17:0]                beta;
    logic [1:0]                        new_kind;
    logic                              depth_ok;
    logic                              cut;

    assign is_store  = (i_req.operation == ttps_pkg::OP_STORE);
    assign req_tag   = i_req.position_key[ttps_pkg::KEY_BITS-1:ttps_pkg::INDEX_BITS];

    // A cleared entry holds key zero, so it matches only in slot zero
    assign key_match = (i_entry.tag == req_tag) &&
                       ((i_entry.kind != ttps_pkg::KIND_EMPTY) ||
                        (i_req.position_key[ttps_pkg::INDEX_BITS-1:0] == '0));

    // Widen operands for signed compares
    assign thr      = signed'({3'b000, i_threshold});
    assign ply      = signed'({{(18 - ttps_pkg::DEPTH_BITS){1'b0}}, i_req.ply_distance});
    assign in_score = 18'(i_req.store_score);
    assign st_score = 18'(signed'(i_entry.score));
    assign alpha    = 18'(i_req.window_low);
    assign beta     = 18'(i_req.window_high);

    // Push mate scores away from the root on store
    always_comb begin
        if (in_score > thr) begin
            in_shifted = in_score + ply;
        end else if (in_score < -thr) begin
            in_shifted = in_score - ply;
        end else begin
            in_shifted = in_score;
        end
    end

    // Pull mate scores back towards the root on probe
    always_comb begin
        if (st_score > thr) begin
            out_shifted = st_score - ply;
        end else if (st_score < -thr) begin
            out_shifted = st_score + ply;
        end else begin
            out_shifted = st_score;
        end
    end

    // Map request bound to stored kind; the unused code saturates to lower
    always_comb begin
        case (i_req.bound_kind)
            ttps_pkg::BOUND_EXACT: new_kind = ttps_pkg::KIND_EXACT;
            ttps_pkg::BOUND_UPPER: new_kind = ttps_pkg::KIND_UPPER;
            default:               new_kind = ttps_pkg::KIND_LOWER;
        endcase
    end

    // Keep a deeper exact entry for the same position
    assign keep_old = key_match && (i_entry.depth > i_req.search_depth) &&
                      (i_entry.kind == ttps_pkg::KIND_EXACT);

    assign o_wr.en          = is_store && !keep_old;
    assign o_wr.idx         = i_req.position_key[ttps_pkg::INDEX_BITS-1:0];
    assign o_wr.entry.tag   = req_tag;
    assign o_wr.entry.score = in_shifted[15:0];
    assign o_wr.entry.move  = i_req.packed_move;
    assign o_wr.entry.depth = i_req.search_depth;
    assign o_wr.entry.kind  = new_kind;

    // Decide whether the stored score settles the probe window
    assign depth_ok = (i_entry.depth >= i_req.search_depth) && (i_req.ply_distance != '0);
    assign cut = !is_store && key_match && depth_ok &&
                 ((i_entry.kind == ttps_pkg::KIND_EXACT) ||
                  ((i_entry.kind == ttps_pkg::KIND_LOWER) && (out_shifted >= beta)) ||
                  ((i_entry.kind == ttps_pkg::KIND_UPPER) && (out_shifted <= alpha)));

    assign o_result.hit          = !is_store && key_match;
    assign o_result.move_hint    = (!is_store && key_match) ? i_entry.move : 16'd0;
    assign o_result.cutoff       = cut;
    assign o_result.cutoff_score = cut ? signed'(out_shifted[15:0]) : 16'sd0;

endmodule

[hw/rtl/transposition_table_probe_store.sv]
`timescale 1ns / 1ps
// Direct-mapped transposition table: probe and store requests.
// Input channel (i_in_valid / o_in_stall, i_in_data): one request per
// transaction, probe or store. Output channel (o_out_valid / i_out_stall,
// o_out_data): exactly one result per request, in request order; stores
// return an all-zero result.
// Configuration channel (i_cfg_valid / o_cfg_ready, i_cfg_data): writes the
// mate threshold; always ready, also during the clearing pass.
// A request is registered into the evaluate stage with its table read, and
// its result is registered into the output register. Throughput: one
// request per cycle while the output does not stall, set by the single
// read-modify-write of the table memory; a write from the previous request
// to the same entry is forwarded from a register.
// Reset: the mate threshold returns to 31000 and the table is cleared by a
// pass that writes one entry a cycle over all 2048 entries, during which
// o_in_stall is high.
// Output stall: the result register holds, the request in the evaluate
// stage waits, and, if that stage holds a request, o_in_stall rises in the same cycle.
`include "transposition_table_probe_store_defines.svh"

module transposition_table_probe_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  ttps_pkg::t_in                 i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output ttps_pkg::t_out                o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ttps_pkg::THR_BITS-1:0] i_cfg_data
);

    logic [ttps_pkg::THR_BITS-1:0]   r_threshold;
    logic                            r_clearing;
    logic [ttps_pkg::INDEX_BITS-1:0] r_clr_idx;
    logic                            r_s2_valid;
    ttps_pkg::t_in                   r_s2_req;
    logic                            r_out_valid;
    ttps_pkg::t_out                  r_out_data;
    logic                            r_fwd_valid;
    logic [ttps_pkg::INDEX_BITS-1:0] r_fwd_idx;
    ttps_pkg::t_entry                r_fwd_entry;

    logic                            in_acc;
    logic                            s2_adv;
    logic [ttps_pkg::ENTRY_BITS-1:0] ram_rdata;
    ttps_pkg::t_entry                cur_entry;
    ttps_pkg::t_out                  result;
    ttps_pkg::t_wr                   eval_wr;
    logic                            ram_we;
    logic [ttps_pkg::INDEX_BITS-1:0] ram_waddr;
    ttps_pkg::t_entry                ram_wentry;

    // Handshake control
    assign s2_adv      = r_s2_valid && (!r_out_valid || !i_out_stall);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = r_clearing || (r_s2_valid && !s2_adv);
    assign o_cfg_ready = 1'b1;

    // Mate threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= ttps_pkg::MATE_THRESHOLD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_threshold <= i_cfg_data;
        end
    end

    // Clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == {ttps_pkg::INDEX_BITS{1'b1}}) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // Table memory write mux
    assign ram_we     = r_clearing || (s2_adv && eval_wr.en);
    assign ram_waddr  = r_clearing ? r_clr_idx : eval_wr.idx;
    assign ram_wentry = r_clearing ? '0 : eval_wr.entry;

    ttps_ram #(
        .WIDTH (ttps_pkg::ENTRY_BITS),
        .DEPTH (ttps_pkg::TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wentry),
        .i_re    (in_acc),
        .i_raddr (i_in_data.position_key[ttps_pkg::INDEX_BITS-1:0]),
        .o_rdata (ram_rdata)
    );

    // Forward the write that coincided with this request's read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else if (s2_adv && eval_wr.en) begin
            r_fwd_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_adv && eval_wr.en) begin
            r_fwd_idx   <= eval_wr.idx;
            r_fwd_entry <= eval_wr.entry;
        end
    end

    assign cur_entry = (r_fwd_valid &&
                        (r_fwd_idx == r_s2_req.position_key[ttps_pkg::INDEX_BITS-1:0])) ?
                       r_fwd_entry : ttps_pkg::t_entry'(ram_rdata);

    // Evaluate stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (in_acc) begin
            r_s2_valid <= 1'b1;
        end else if (s2_adv) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s2_req <= i_in_data;
        end
    end

    ttps_eval u_eval (
        .i_req       (r_s2_req),
        .i_entry     (cur_entry),
        .i_threshold (r_threshold),
        .o_result    (result),
        .o_wr        (eval_wr)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_adv) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Checks
    `TTPS_ASSERT_NOW(a_no_accept_in_clear, i_clk, i_rst_n, r_clearing, !in_acc)
    `TTPS_ASSERT_NOW(a_write_source, i_clk, i_rst_n, ram_we, r_clearing || s2_adv)
    `TTPS_ASSERT_NEXT(a_accept_fills_s2, i_clk, i_rst_n, in_acc, r_s2_valid)
    `TTPS_ASSERT_NEXT(a_s2_holds, i_clk, i_rst_n, r_s2_valid && !s2_adv, r_s2_valid && $stable(r_s2_req))
    `TTPS_ASSERT_NOW(a_store_zero, i_clk, i_rst_n, s2_adv && (r_s2_req.operation == ttps_pkg::OP_STORE), result == '0)

endmodule

[dv/transposition_table_probe_store_checker.sv]
`timescale 1ns / 1ps

module transposition_table_probe_store_checker
    import ttps_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  t_in                 i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  t_out                i_out_data,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [THR_BITS-1:0] i_cfg_data,
    output int                  o_fail_count,
    output int                  o_pending
);

    // Shadow copy of one table slot, full key kept for the hit compare
    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [15:0]         score;
        logic [15:0]         move;
        logic [7:0]          depth;
        logic [1:0]          kind;
    } tt_slot_t;

    tt_slot_t            tt_shadow [TABLE_DEPTH];
    logic [THR_BITS-1:0] mate_limit;
    t_out                expected_results[$];
    int                  fail_tally;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        fail_tally   = 0;
        mate_limit   = MATE_THRESHOLD_RESET;
    end

    // Move a mate score by step; scores inside the threshold stay put
    function automatic int mate_shift(input int s, input int step);
        int t;
        t = int'(mate_limit);
        if (s > t) return s + step;
        if (s < -t) return s - step;
        return s;
    endfunction

    // Apply one probe or store to the shadow table and return its result
    function automatic t_out table_access(input t_in req);
        logic [INDEX_BITS-1:0] slot;
        tt_slot_t              ent;
        logic [1:0]            bound;
        int                    s;
        t_out                  res;
        res  = '0;
        slot = req.position_key[INDEX_BITS-1:0];
        ent  = tt_shadow[slot];
        if (req.operation == OP_STORE) begin
            bound = (req.bound_kind > BOUND_LOWER) ? BOUND_LOWER : req.bound_kind;
            // keep a deeper exact entry of the same position
            if (!(ent.key == req.position_key && ent.depth > {1'b0, req.search_depth} &&
                  ent.kind == KIND_EXACT)) begin
                s         = mate_shift(int'(req.store_score), int'(req.ply_distance));
                ent.key   = req.position_key;
                ent.score = s[15:0];
                ent.move  = req.packed_move;
                ent.depth = {1'b0, req.search_depth};
                ent.kind  = bound + 2'd1;
                tt_shadow[slot] = ent;
            end
        end else if (ent.key == req.position_key) begin
            res.hit       = 1'b1;
            res.move_hint = ent.move;
            if (ent.depth >= {1'b0, req.search_depth} && req.ply_distance != '0) begin
                s = mate_shift(int'($signed(ent.score)), -int'(req.ply_distance));
                if (ent.kind == KIND_EXACT ||
                    (ent.kind == KIND_LOWER && s >= int'(req.window_high)) ||
                    (ent.kind == KIND_UPPER && s <= int'(req.window_low))) begin
                    res.cutoff       = 1'b1;
                    res.cutoff_score = s[15:0];
                end
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            // clear the shadow table and the threshold as the block does
            foreach (tt_shadow[i]) tt_shadow[i] = '0;
            mate_limit <= MATE_THRESHOLD_RESET;
            expected_results.delete();
        end else begin
            // compare each result transaction with the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result transaction with no request outstanding: %p", i_out_data);
                    fail_tally++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_data.hit !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, i_out_data.hit);
                        fail_tally++;
                    end
                    if (i_out_data.move_hint !== want.move_hint) begin
                        $error("move_hint: expected 0x%04h, got 0x%04h",
                               want.move_hint, i_out_data.move_hint);
                        fail_tally++;
                    end
                    if (i_out_data.cutoff !== want.cutoff) begin
                        $error("cutoff: expected %0d, got %0d", want.cutoff, i_out_data.cutoff);
                        fail_tally++;
                    end
                    if (i_out_data.cutoff_score !== want.cutoff_score) begin
                        $error("cutoff_score: expected %0d, got %0d",
                               want.cutoff_score, i_out_data.cutoff_score);
                        fail_tally++;
                    end
                end
            end
            // predict each request transaction
            if (i_in_valid && !i_in_stall) begin
                expected_results.push_back(table_access(i_in_data));
            end
            if (i_cfg_valid && i_cfg_ready) begin
                mate_limit <= i_cfg_data;
            end
        end
        o_pending    <= expected_results.size();
        o_fail_count <= fail_tally;
    end

endmodule

[dv/transposition_table_probe_store_tb.sv]
`timescale 1ns / 1ps

module transposition_table_probe_store_tb;
    import ttps_pkg::*;

    localparam int         IDLE_LIMIT     = 10000;
    localparam int         ITEMS_PER_RUN  = 400;
    localparam logic [1:0] BOUND_RESERVED = 2'd3;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                in_valid    = 1'b0;
    logic                o_in_stall;
    t_in                 in_data     = '0;
    logic                o_out_valid;
    logic                out_stall   = 1'b0;
    t_out                o_out_data;
    logic                cfg_valid   = 1'b0;
    logic                o_cfg_ready;
    logic [THR_BITS-1:0] cfg_data    = '0;
    int                  fail_count;
    int                  pending;

    int                  burst_left  = 0;
    int                  idle_cycles = 0;
    int                  stall_mode  = 0;
    int                  mode_left   = 0;
    int                  run_left    = 0;
    int                  mate_limit  = 31000;
    logic [KEY_BITS-1:0] key_pool [48];

    transposition_table_probe_store dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    transposition_table_probe_store_checker tt_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (o_out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // End the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall) ||
                (cfg_valid && o_cfg_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[transposition_table_probe_store] ERROR");
                $finish;
            end
        end
    end

    // Receiver stall: free, sparse, coin-toss or long runs, switched at random
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(20, 300);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            0: begin
                out_stall <= 1'b0;
            end
            1: begin
                out_stall <= ($urandom_range(0, 3) == 0);
            end
            2: begin
                out_stall <= 1'($urandom_range(0, 1));
            end
            default: begin
                if (run_left == 0) begin
                    run_left  <= $urandom_range(1, 40);
                    out_stall <= ~out_stall;
                end else begin
                    run_left <= run_left - 1;
                end
            end
        endcase
    end

    function automatic t_in make_req(input logic op, input logic [31:0] key,
                                     input int depth, input int ply, input int score,
                                     input logic [1:0] kind, input logic [15:0] move,
                                     input int lo, input int hi);
        t_in r;
        r.operation    = op;
        r.position_key = key;
        r.search_depth = depth[DEPTH_BITS-1:0];
        r.ply_distance = ply[DEPTH_BITS-1:0];
        r.store_score  = score[15:0];
        r.bound_kind   = kind;
        r.packed_move  = move;
        r.window_low   = lo[15:0];
        r.window_high  = hi[15:0];
        return r;
    endfunction

    // Scores cluster around the mate threshold, the extremes and zero
    function automatic logic signed [15:0] pick_score();
        int s;
        case ($urandom_range(0, 5))
            0:       s = int'($urandom_range(0, 65535)) - 32768;
            1, 2:    s = mate_limit + int'($urandom_range(0, 8)) - 4;
            3:       s = int'($urandom_range(0, 1000)) - 500;
            4:       s = ($urandom_range(0, 1) == 1) ? 32767 : -32767 - int'($urandom_range(0, 1));
            default: s = int'($urandom_range(mate_limit, 32767));
        endcase
        if ($urandom_range(0, 1) == 1) s = -s;
        return s[15:0];
    endfunction

    function automatic t_in random_req();
        t_in r;
        r.operation    = ($urandom_range(0, 99) < 55) ? OP_PROBE : OP_STORE;
        r.position_key = ($urandom_range(0, 9) == 0) ? $urandom() :
                         key_pool[$urandom_range(0, 47)];
        r.search_depth = ($urandom_range(0, 3) == 0) ? DEPTH_BITS'($urandom_range(0, 127)) :
                         DEPTH_BITS'($urandom_range(0, 12));
        case ($urandom_range(0, 9))
            0:       r.ply_distance = '0;
            1, 2:    r.ply_distance = DEPTH_BITS'($urandom_range(0, 127));
            default: r.ply_distance = DEPTH_BITS'($urandom_range(1, 20));
        endcase
        r.store_score  = pick_score();
        r.bound_kind   = 2'($urandom_range(0, 3));
        r.packed_move  = ($urandom_range(0, 4) == 0) ? 16'h0000 :
                         16'($urandom_range(0, 65535));
        r.window_low   = pick_score();
        r.window_high  = pick_score();
        return r;
    endfunction

    // Offer one request; bursts of random length with random gaps between them
    task automatic push_request(input t_in req);
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) :
                         $urandom_range(1, 24);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Hold the sender until every outstanding result has come back
    task automatic drain_results();
        in_valid   <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_mate_limit(input int value);
        cfg_valid <= 1'b1;
        cfg_data  <= value[THR_BITS-1:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_valid  <= 1'b0;
        mate_limit = value;
    endtask

    initial begin
        int   thresholds [5];
        logic [INDEX_BITS-1:0] index_set [16];
        foreach (index_set[i]) index_set[i] = INDEX_BITS'($urandom_range(0, TABLE_DEPTH - 1));
        foreach (key_pool[i]) begin
            key_pool[i] = $urandom();
            key_pool[i][INDEX_BITS-1:0] = index_set[i % 16];
        end
        key_pool[0] = '0;
        key_pool[1] = '1;
        thresholds = '{0, 32767, 31000, 200, int'($urandom_range(0, 32767))};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: replacement rule, bound kinds, mate shifts, ply zero, empty slot
        write_mate_limit(30000);
        push_request(make_req(OP_PROBE, 32'h0, 0, 1, 0, BOUND_EXACT, 16'h0, 0, 0));
        push_request(make_req(OP_STORE, 32'h5, 10, 3, 32767, BOUND_EXACT, 16'hFFFF, 0, 0));
        push_request(make_req(OP_PROBE, 32'h5, 10, 3, 0, BOUND_EXACT, 16'h0, -32768, 32767));
        push_request(make_req(OP_STORE, 32'h5, 5, 1, 0, BOUND_EXACT, 16'h0001, 0, 0));
        push_request(make_req(OP_PROBE, 32'h5, 127, 1, 0, BOUND_EXACT, 16'h0, 0, 0));
        push_request(make_req(OP_PROBE, 32'h5, 0, 0, 0, BOUND_EXACT, 16'h0, 0, 0));
        push_request(make_req(OP_STORE, 32'h5, 10, 1, -100, BOUND_UPPER, 16'h0002, 0, 0));
        push_request(make_req(OP_PROBE, 32'h5, 10, 2, 0, BOUND_EXACT, 16'h0, -100, 0));
        push_request(make_req(OP_PROBE, 32'h5, 10, 2, 0, BOUND_EXACT, 16'h0, -101, 0));
        push_request(make_req(OP_STORE, 32'h805, 0, 0, 123, BOUND_LOWER, 16'h0003, 0, 0));
        push_request(make_req(OP_PROBE, 32'h5, 0, 1, 0, BOUND_EXACT, 16'h0, 0, 0));
        push_request(make_req(OP_PROBE, 32'h805, 0, 1, 0, BOUND_EXACT, 16'h0, 0, 123));
        push_request(make_req(OP_PROBE, 32'h805, 0, 1, 0, BOUND_EXACT, 16'h0, 0, 124));
        push_request(make_req(OP_STORE, 32'hFFFF_FFFF, 127, 127, -32768, BOUND_RESERVED,
                              16'h1234, 0, 0));
        push_request(make_req(OP_PROBE, 32'hFFFF_FFFF, 127, 127, 0, BOUND_EXACT, 16'h0,
                              32767, -32768));
        push_request(make_req(OP_STORE, 32'h123, 3, 7, -31500, BOUND_EXACT, 16'hABCD, 0, 0));
        push_request(make_req(OP_PROBE, 32'h123, 3, 1, 0, BOUND_EXACT, 16'h0, 0, 0));
        push_request(make_req(OP_STORE, 32'h123, 2, 1, 5, BOUND_LOWER, 16'h0004, 0, 0));
        push_request(make_req(OP_PROBE, 32'h123, 4, 1, 0, BOUND_EXACT, 16'h0, 0, 0));
        push_request(make_req(OP_STORE, 32'h8000_0000, 127, 0, 32767, BOUND_EXACT,
                              16'h8000, 0, 0));
        push_request(make_req(OP_PROBE, 32'h8000_0000, 127, 127, 0, BOUND_EXACT, 16'h0,
                              32767, -32768));
        push_request(make_req(OP_PROBE, 32'h7FFF_FFFF, 0, 64, 0, BOUND_EXACT, 16'h0, 0, 0));
        push_request(make_req(OP_STORE, 32'h7FF, 0, 0, 31001, BOUND_UPPER, 16'h7FFF, 0, 0));
        push_request(make_req(OP_PROBE, 32'h7FF, 0, 5, 0, BOUND_EXACT, 16'h0, 32767, 0));
        drain_results();

        // Random runs, one threshold per run, idle between runs
        foreach (thresholds[p]) begin
            write_mate_limit(thresholds[p]);
            for (int n = 0; n < ITEMS_PER_RUN; n++) begin
                if (p == 1 && n == ITEMS_PER_RUN / 2) drain_results();
                push_request(random_req());
            end
            drain_results();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("[transposition_table_probe_store] OK");
        end else begin
            $display("[transposition_table_probe_store] ERROR");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/ttps_pkg.sv
hw/rtl/ttps_ram.sv
hw/rtl/ttps_eval.sv
hw/rtl/transposition_table_probe_store.sv
dv/transposition_table_probe_store_checker.sv
dv/transposition_table_probe_store_tb.sv
